// ----- rtl/tpd_pkg.sv -----
// Shared types and constants for the tuner PLL divider calculation.
// No dependencies; used by every module under rtl/.
`default_nettype none

package tpd_pkg;

  localparam int TUNE_W = 24;
  localparam int REF_W  = 16;
  localparam int VCO_W  = 25;   // 2*F at most 25 bits, 4*F below the divider limit too
  localparam int REM_W  = 17;   // remainder stays below the 17-bit divisor
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [REF_W-1:0]  REF_RESET_KHZ  = 16'd27000;
  localparam logic [TUNE_W-1:0] ODIV_LIMIT_KHZ = 24'd1075000;
  localparam logic [TUNE_W-1:0] HIGH_PSD_KHZ   = 24'd13260000;
  localparam logic [7:0]        VCO_WORD_BASE  = 8'h80;

  localparam int BAND_ROWS = 10;
  localparam logic [3:0] BAND_TOP_CODE = 4'hC;

  // Upper edge of each band row, first match wins
  localparam logic [TUNE_W-1:0] BAND_HIGH [BAND_ROWS] = '{
    24'd1000000, 24'd1075000, 24'd1200000, 24'd1300000, 24'd1370000,
    24'd1470000, 24'd1530000, 24'd1650000, 24'd1800000, 24'd1950000
  };
  localparam logic [3:0] BAND_CODE [BAND_ROWS] = '{
    4'hA, 4'hC, 4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h8, 4'hA
  };

  typedef struct packed {
    logic [3:0] band;
    logic       odiv;
    logic       psd2;
    logic       base_zero;
  } tpd_side_t;

  // Below the table falls into the first row, above it into the top code
  function automatic logic [3:0] pick_band(input logic [TUNE_W-1:0] f);
    logic [3:0] code;
    code = BAND_TOP_CODE;
    for (int r = BAND_ROWS - 1; r >= 0; r--) begin
      if (f <= BAND_HIGH[r]) begin
        code = BAND_CODE[r];
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tpd_front.sv -----
// Front stage: band lookup, divider and prescaler bits, VCO and divisor.
// Depends on tpd_pkg.
`default_nettype none

module tpd_front
  import tpd_pkg::*;
#(
  parameter int FRAC_BITS = 9
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [TUNE_W-1:0]               tune_khz,
  input  wire logic [REF_W-1:0]                reference_khz,
  output logic                                 out_valid,
  output logic [REM_W-1:0]                     out_base,
  output logic [VCO_W+FRAC_BITS-1:0]           out_dvd,
  output tpd_side_t                            out_side
);

  logic             odiv;
  logic             psd2;
  logic [VCO_W-1:0] vco;
  logic [REM_W-1:0] base;

  always_comb begin
    odiv = (tune_khz <= ODIV_LIMIT_KHZ);
    psd2 = odiv || (tune_khz >= HIGH_PSD_KHZ);
    vco  = odiv ? {tune_khz[TUNE_W-2:0], 2'b00} : {tune_khz, 1'b0};
    base = psd2 ? {reference_khz, 1'b0} : {1'b0, reference_khz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_base            <= base;
    out_dvd             <= {vco, {FRAC_BITS{1'b0}}};
    out_side.band       <= pick_band(tune_khz);
    out_side.odiv       <= odiv;
    out_side.psd2       <= psd2;
    out_side.base_zero  <= (reference_khz == '0);
  end

endmodule

`default_nettype wire

// ----- rtl/tpd_div_stage.sv -----
// One registered slice of the restoring divider: STEPS quotient bits per beat.
// Depends on tpd_pkg.
`default_nettype none

module tpd_div_stage
  import tpd_pkg::*;
#(
  parameter int QW    = 34,
  parameter int STEPS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [REM_W-1:0]  in_rem,
  input  wire logic [QW-1:0]     in_dvd,
  input  wire logic [REM_W-1:0]  in_base,
  input  wire tpd_side_t         in_side,
  output logic                   out_valid,
  output logic [REM_W-1:0]       out_rem,
  output logic [QW-1:0]          out_dvd,
  output logic [REM_W-1:0]       out_base,
  output tpd_side_t              out_side
);

  logic [REM_W-1:0] rem;
  logic [QW-1:0]    dvd;
  logic [REM_W:0]   trial;
  logic             ge;

  // Dividend bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    rem   = in_rem;
    dvd   = in_dvd;
    trial = '0;
    ge    = 1'b0;
    for (int s = 0; s < STEPS; s++) begin
      trial = {rem, dvd[QW-1]};
      ge    = (trial >= {1'b0, in_base});
      rem   = ge ? REM_W'(trial - {1'b0, in_base}) : trial[REM_W-1:0];
      dvd   = {dvd[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= rem;
    out_dvd  <= dvd;
    out_base <= in_base;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ----- rtl/tuner_pll_divider_calc.sv -----
// Top level: reference register, front stage, divider pipeline, result register.
// Depends on tpd_pkg, tpd_front and tpd_div_stage.
//
//   channel   signals                              dir   beat taken when
//   config    cfg_write, cfg_data[15:0]            in    cfg_write high
//   request   start, busy, tune_khz[23:0]          in    start high, busy low
//   result    done, band_code .. vco_word          out   done high (one cycle)
//
// A request is taken in every cycle; busy stays low.
// A result passes the front stage register, the divider pipeline, which resolves four
// quotient bits per stage (the last stage the rest), then the result register.
// Synchronous reset empties the pipeline and loads the reference with 27000 kHz.
// The result side cannot stall, so the pipeline simply advances every cycle.
`default_nettype none

module tuner_pll_divider_calc
  import tpd_pkg::*;
#(
  parameter int FRAC_BITS = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [REF_W-1:0]  cfg_data,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [TUNE_W-1:0] tune_khz,
  output logic                   done,
  output logic [3:0]             band_code,
  output logic                   out_div,
  output logic                   prescale,
  output logic [7:0]             int_div,
  output logic                   int_overflow,
  output logic [8:0]             frac_div,
  output logic [7:0]             vco_word
);

  localparam int QW      = VCO_W + FRAC_BITS;
  localparam int NSTAGE  = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int LAST    = QW - STEPS_PER_STAGE * (NSTAGE - 1);
  localparam int LATENCY = NSTAGE + 2;

  logic [REF_W-1:0] reference_khz;

  logic             v   [NSTAGE+1];
  logic [REM_W-1:0] rem [NSTAGE+1];
  logic [QW-1:0]    dvd [NSTAGE+1];
  logic [REM_W-1:0] base[NSTAGE+1];
  tpd_side_t        side[NSTAGE+1];

  logic [QW-1:0]    q;
  tpd_side_t        fs;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_khz <= REF_RESET_KHZ;
    end else if (cfg_write) begin
      reference_khz <= cfg_data;
    end
  end

  tpd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .tune_khz      (tune_khz),
    .reference_khz (reference_khz),
    .out_valid     (v[0]),
    .out_base      (base[0]),
    .out_dvd       (dvd[0]),
    .out_side      (side[0])
  );

  assign rem[0] = '0;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_div
    localparam int S = (i == NSTAGE - 1) ? LAST : STEPS_PER_STAGE;
    tpd_div_stage #(
      .QW    (QW),
      .STEPS (S)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_rem    (rem[i]),
      .in_dvd    (dvd[i]),
      .in_base   (base[i]),
      .in_side   (side[i]),
      .out_valid (v[i+1]),
      .out_rem   (rem[i+1]),
      .out_dvd   (dvd[i+1]),
      .out_base  (base[i+1]),
      .out_side  (side[i+1])
    );
  end

  assign q  = dvd[NSTAGE];
  assign fs = side[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[NSTAGE];
    end
  end

  // Zero reference saturates the integer part and clears the fraction
  always_ff @(posedge clk) begin
    band_code    <= fs.band;
    out_div      <= fs.odiv;
    prescale     <= fs.psd2;
    int_div      <= fs.base_zero ? 8'hFF : q[FRAC_BITS +: 8];
    int_overflow <= fs.base_zero || (|q[QW-1:FRAC_BITS+8]);
    frac_div     <= fs.base_zero ? 9'd0 : 9'(q[FRAC_BITS-1:0]);
    vco_word     <= VCO_WORD_BASE | {3'b000, fs.odiv, fs.band};
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("accepted request gave no result at the expected latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !start |-> ##LATENCY !done)
    else $error("result without a matching request");

  a_odiv_psd : assert property (@(posedge clk) disable iff (rst)
    (done && out_div) |-> prescale)
    else $error("output divider set without prescaler");

  a_vco_word : assert property (@(posedge clk) disable iff (rst)
    done |-> (vco_word[7] && (vco_word[4] == out_div) && (vco_word[3:0] == band_code)))
    else $error("VCO word disagrees with band code or divider bit");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for tuner_pll_divider_calc: directed and random tuning requests
// checked against a scoreboard that predicts band, dividers and fraction per request.
// Depends on tpd_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
  import tpd_pkg::*;

  localparam int FRAC_BITS   = 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int FLUSH_WAIT  = 24;
  localparam int TABLE_ROWS  = 11;
  localparam logic [TUNE_W-1:0] TABLE_MIN_KHZ = 24'd950000;
  localparam logic [TUNE_W-1:0] TABLE_MAX_KHZ = 24'd2150000;

  typedef struct packed {
    logic [3:0] band_code;
    logic       out_div;
    logic       prescale;
    logic [7:0] int_div;
    logic       int_overflow;
    logic [8:0] frac_div;
    logic [7:0] vco_word;
  } tune_result_t;

  class divider_scoreboard;
    logic [REF_W-1:0] ref_khz;
    tune_result_t     settings_q[$];
    int               errors;

    function new();
      ref_khz = REF_RESET_KHZ;
      errors  = 0;
    endfunction

    // First closed range that holds f wins; clamp outside the table
    function logic [3:0] band_of(logic [TUNE_W-1:0] f);
      logic [TUNE_W-1:0] lo [TABLE_ROWS];
      logic [TUNE_W-1:0] hi [TABLE_ROWS];
      logic [3:0]        code [TABLE_ROWS];
      lo   = '{24'd950000, 24'd1000000, 24'd1075000, 24'd1200000, 24'd1300000,
               24'd1370000, 24'd1470000, 24'd1530000, 24'd1650000, 24'd1800000,
               24'd1950000};
      hi   = '{24'd1000000, 24'd1075000, 24'd1200000, 24'd1300000, 24'd1370000,
               24'd1470000, 24'd1530000, 24'd1650000, 24'd1800000, 24'd1950000,
               24'd2150000};
      code = '{4'hA, 4'hC, 4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h8, 4'hA, 4'hC};
      if (f < TABLE_MIN_KHZ) return code[0];
      if (f > TABLE_MAX_KHZ) return code[TABLE_ROWS-1];
      for (int r = 0; r < TABLE_ROWS - 1; r++) begin
        if (f >= lo[r] && f <= hi[r]) return code[r];
      end
      return code[TABLE_ROWS-1];
    endfunction

    function tune_result_t settings_for(logic [TUNE_W-1:0] f);
      tune_result_t r;
      logic [63:0]  vco, base, ni, rem, nf;
      r.band_code = band_of(f);
      r.out_div   = (f <= ODIV_LIMIT_KHZ);
      r.prescale  = (f <= ODIV_LIMIT_KHZ) || (f >= HIGH_PSD_KHZ);
      vco  = 64'(f) * 64'(2) * (64'(r.out_div) + 64'd1);
      base = 64'(ref_khz) * (64'(r.prescale) + 64'd1);
      if (base == 0) begin
        // zero reference saturates the divider
        ni = 64'd256;
        nf = 0;
        r.int_div = 8'hFF;
      end else begin
        ni  = vco / base;
        rem = vco - ni * base;
        nf  = (rem << FRAC_BITS) / base;
        r.int_div = ni[7:0];
      end
      r.int_overflow = (ni > 64'd255);
      r.frac_div     = nf[8:0];
      r.vco_word     = VCO_WORD_BASE | {3'b000, r.out_div, r.band_code};
      return r;
    endfunction

    function void note_request(logic [TUNE_W-1:0] f);
      settings_q.push_back(settings_for(f));
    endfunction

    function void field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $error("%s: expected %0d, actual %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(tune_result_t got);
      tune_result_t exp;
      if (settings_q.size() == 0) begin
        $error("result with no request outstanding: vco_word %0d", got.vco_word);
        errors++;
        return;
      end
      exp = settings_q.pop_front();
      field("band_code", exp.band_code, got.band_code);
      field("out_div", exp.out_div, got.out_div);
      field("prescale", exp.prescale, got.prescale);
      field("int_div", exp.int_div, got.int_div);
      field("int_overflow", exp.int_overflow, got.int_overflow);
      field("frac_div", exp.frac_div, got.frac_div);
      field("vco_word", exp.vco_word, got.vco_word);
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic [REF_W-1:0]  cfg_data  = '0;
  logic              start     = 1'b0;
  logic [TUNE_W-1:0] tune_khz  = '0;
  logic              busy;
  logic              done;
  logic [3:0]        band_code;
  logic              out_div;
  logic              prescale;
  logic [7:0]        int_div;
  logic              int_overflow;
  logic [8:0]        frac_div;
  logic [7:0]        vco_word;

  divider_scoreboard sb = new();
  int unsigned       cycles = 0;

  tuner_pll_divider_calc #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .tune_khz     (tune_khz),
    .done         (done),
    .band_code    (band_code),
    .out_div      (out_div),
    .prescale     (prescale),
    .int_div      (int_div),
    .int_overflow (int_overflow),
    .frac_div     (frac_div),
    .vco_word     (vco_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({band_code, out_div, prescale, int_div, int_overflow,
                       frac_div, vco_word});
    end
  end

  // Hold start high between back-to-back beats; drop it only for a gap
  task automatic send_tune(input logic [TUNE_W-1:0] f, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    tune_khz <= f;
    do @(posedge clk); while (busy);
    sb.note_request(f);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.settings_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reference(input logic [REF_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.ref_khz = v;
  endtask

  task automatic send_directed();
    logic [TUNE_W-1:0] pts [$];
    pts = '{24'd0, 24'd1, 24'd949999, 24'd950000, 24'd1000000, 24'd1000001,
            24'd1075000, 24'd1075001, 24'd1200000, 24'd1200001, 24'd1300000,
            24'd1370000, 24'd1470000, 24'd1530000, 24'd1650000, 24'd1800000,
            24'd1950000, 24'd1950001, 24'd2150000, 24'd2150001, 24'd13259999,
            24'd13260000, 24'h555555, 24'hAAAAAA, 24'hFFFFFF};
    foreach (pts[i]) send_tune(pts[i], (i % 3 == 0) ? $urandom_range(0, 3) : 0);
  endtask

  function automatic logic [TUNE_W-1:0] random_tune();
    logic [TUNE_W-1:0] edges [11];
    int                pick;
    edges = '{24'd950000, 24'd1000000, 24'd1075000, 24'd1200000, 24'd1300000,
              24'd1370000, 24'd1470000, 24'd1530000, 24'd1650000, 24'd1950000,
              24'd13260000};
    pick = $urandom_range(0, 99);
    if (pick < 40) return 24'($urandom_range(900000, 2200000));
    if (pick < 55) return edges[$urandom_range(0, 10)] + 24'($urandom_range(0, 4)) - 24'd2;
    if (pick < 70) return 24'($urandom_range(13000000, 16777215));
    return 24'($urandom);
  endfunction

  task automatic run_phase(input int count, input bit no_idle);
    for (int i = 0; i < count; i++) begin
      // pause the sender once per phase until the pipeline has emptied
      if (i == count / 2) drain_results();
      send_tune(random_tune(), no_idle ? 0 : $urandom_range(0, 19));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset reference first, then the extremes including a zero reference
    send_directed();
    drain_results();
    write_reference(16'd0);
    send_directed();
    drain_results();
    write_reference(16'd1000);
    send_directed();
    drain_results();
    write_reference(16'hFFFF);
    send_directed();

    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        0: write_reference(REF_RESET_KHZ);
        1: write_reference(16'd1000);
        2: write_reference(16'hFFFF);
        3: write_reference(16'd0);
        4: write_reference(16'd1);
        default: write_reference(16'($urandom_range(1000, 65535)));
      endcase
      run_phase(200, (p % 3) == 1);
    end

    drain_results();
    repeat (FLUSH_WAIT) @(posedge clk);
    if (sb.settings_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.settings_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
